/* rtl/gndm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gndm_pkg: shared types and constants of the grey neighbour difference mask
// Beat payloads, configuration register codes and the push record that the
// issue logic hands to the line store and window.
// ----------------------------------------------------------------------------
package gndm_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = 16;
    localparam int GREY_W      = 8;
    localparam int MASK_W      = 8;
    localparam int WIDTH_REG_W = 11;
    localparam int FILL_W      = $clog2(MAX_WIDTH + 3);
    localparam int PEND_W      = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // Input item kinds
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [GREY_W-1:0] red;
        logic [GREY_W-1:0] green;
        logic [GREY_W-1:0] blue;
    } t_pixel_in;

    typedef struct packed {
        logic [GREY_W-1:0] grey_level;
        logic [MASK_W-1:0] blocked_mask;
        logic [COL_W-1:0]  pixel_column;
        logic [ROW_W-1:0]  pixel_row;
        logic              frame_last;
    } t_result_out;

    // Frame borders touched by the reported pixel
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_border;

    // One push into the line store, with the report that it completes
    typedef struct packed {
        logic              vld;
        logic              emit;
        logic [COL_W-1:0]  addr;
        logic [GREY_W-1:0] grey;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              last;
        t_border           border;
    } t_push;

    // Reports still travelling towards the result queue
    typedef struct packed {
        logic b_emit;
        logic c_emit;
    } t_flight;

endpackage
`default_nettype wire

/* rtl/grey_neighbour_difference_mask_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grey_neighbour_difference_mask_core: grey level and neighbour mask per pixel
// Averages each RGB pixel to grey and reports, one image width and one pixel
// later, which of its eight neighbours are off the frame or of another grey.
// ----------------------------------------------------------------------------
// The core takes one beat per clock: a pixel beat is accepted every cycle as
// long as the four-entry result queue has room, and a steady stream gives one
// result beat per clock unless the receiver stalls. A pixel is reported once
// the pixel width+1 places after it has arrived, so the first width+1 pixels
// of a frame give no result; a result passes the write stage, the report
// register and the result queue on its way to the output. Flush beats drain
// the pending reports one per beat. A flush that arrives before the window
// is full (a frame shorter than width+2 pixels) pushes zero-grey pixels, one
// per cycle while the result queue has room, until it is; the input is stalled
// meanwhile. Once the last pending report is drained the next pixel starts a
// fresh frame at row 0, column 0. The two earlier rows live in one 1024 x 16
// RAM with a registered read, read and written once per pixel; back-to-back
// accesses to the same column (image width 1) are served by forwarding. Write
// image_width and image_height only while the core is idle: each write
// abandons the frame in progress. A width of 0 acts as 1 and above 1024 as
// 1024; a height of 0 acts as 1. Line store entries never written since
// reset only feed neighbours off the frame, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module grey_neighbour_difference_mask_core import gndm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // pixel beats in
    input  wire logic                  i_pix_valid,
    output logic                       o_pix_stall,
    input  wire t_pixel_in             i_pix,
    // result beats out
    output logic                       o_res_valid,
    input  wire logic                  i_res_stall,
    output t_result_out                o_res,
    // configuration writes
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int SUM_W      = GREY_W + 2;
    localparam int PROD_W     = 2 * SUM_W;
    // sum / 3 == (sum * 683) >> 11 for every sum up to 3 * 255
    localparam int GREY_RECIP = 683;
    localparam int GREY_SHIFT = 11;

    localparam logic [PEND_W-1:0] PEND_MAX = {PEND_W{1'b1}};
    localparam logic [PEND_W-1:0] PEND_ONE = PEND_W'(1);

    typedef enum logic [1:0] {
        SEQ_RUN  = 2'b01,
        SEQ_FILL = 2'b10
    } t_seq_state;

    t_seq_state         r_state, n_state;
    logic [COL_W-1:0]   r_w_last, n_w_last;
    logic [ROW_W-1:0]   r_h_last, n_h_last;
    logic [FILL_W-1:0]  r_fill_target, n_fill_target;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [PEND_W-1:0]  r_pending, n_pending;
    logic [COL_W-1:0]   r_col, n_col;
    logic [COL_W-1:0]   r_rc_col, n_rc_col;
    logic [ROW_W-1:0]   r_rc_row, n_rc_row;

    logic               pix_accept;
    logic               credit_ok;
    logic [Q_CNT_W-1:0] occupancy;
    logic [Q_CNT_W-1:0] q_count;
    t_flight            flight;
    logic               fill_full;
    logic               emit_now;
    logic               push;
    logic               emit;
    logic               restart;
    logic [GREY_W-1:0]  push_grey;
    logic [GREY_W-1:0]  pix_grey;
    logic [SUM_W-1:0]   rgb_sum;
    logic [PROD_W-1:0]  rgb_prod;
    logic [WIDTH_REG_W-1:0] cfg_w_raw;
    t_push              push_rec;
    logic               beat_valid;
    t_result_out        beat;

    // Grey level by reciprocal multiply
    assign rgb_sum  = SUM_W'(i_pix.red) + SUM_W'(i_pix.green) + SUM_W'(i_pix.blue);
    assign rgb_prod = PROD_W'(rgb_sum) * PROD_W'(GREY_RECIP);
    assign pix_grey = rgb_prod[GREY_SHIFT +: GREY_W];

    // Count every report in flight against the queue so none can be dropped
    assign occupancy = q_count + Q_CNT_W'(flight.b_emit) + Q_CNT_W'(flight.c_emit);
    assign credit_ok = (occupancy < Q_CNT_W'(Q_DEPTH));

    assign o_pix_stall = (r_state != SEQ_RUN) || !credit_ok;
    assign pix_accept  = i_pix_valid && !o_pix_stall;

    // The window is full once width+2 pixels have gone in
    assign fill_full = (r_fill == r_fill_target);
    assign emit_now  = fill_full || ((r_fill + FILL_W'(1)) == r_fill_target);

    assign cfg_w_raw = i_cfg_wdata[WIDTH_REG_W-1:0];

    always_comb begin
        logic [PEND_W-1:0] pend_up;

        n_state       = r_state;
        n_w_last      = r_w_last;
        n_h_last      = r_h_last;
        n_fill_target = r_fill_target;
        n_fill        = r_fill;
        n_col         = r_col;
        n_rc_col      = r_rc_col;
        n_rc_row      = r_rc_row;
        push          = 1'b0;
        emit          = 1'b0;
        restart       = 1'b0;
        push_grey     = '0;

        unique case (r_state)
            SEQ_RUN: begin
                if (pix_accept) begin
                    if (i_pix.mode == MODE_PIXEL) begin
                        push      = 1'b1;
                        push_grey = pix_grey;
                        emit      = emit_now;
                    end else if (r_pending != '0) begin
                        // flush: push a zero pixel, keep filling if the window is short
                        push = 1'b1;
                        if (emit_now) begin
                            emit    = 1'b1;
                            restart = (r_pending == PEND_ONE);
                        end else begin
                            n_state = SEQ_FILL;
                        end
                    end
                end
            end
            SEQ_FILL: begin
                if (credit_ok) begin
                    push = 1'b1;
                    if (emit_now) begin
                        emit    = 1'b1;
                        restart = (r_pending == PEND_ONE);
                        n_state = SEQ_RUN;
                    end
                end
            end
            default: begin
                n_state = SEQ_RUN;
            end
        endcase

        // pending reports: count pixels in, drop one per report
        pend_up = r_pending;
        if (pix_accept && (i_pix.mode == MODE_PIXEL) && (r_pending != PEND_MAX)) begin
            pend_up = r_pending + PEND_W'(1);
        end
        n_pending = emit ? (pend_up - PEND_W'(1)) : pend_up;

        if (push) begin
            n_col = (r_col == r_w_last) ? '0 : r_col + COL_W'(1);
            if (!fill_full) begin
                n_fill = r_fill + FILL_W'(1);
            end
        end

        // advance the reported position, wrapping at the frame end
        if (emit) begin
            if (r_rc_col == r_w_last) begin
                n_rc_col = '0;
                n_rc_row = (r_rc_row == r_h_last) ? '0 : r_rc_row + ROW_W'(1);
            end else begin
                n_rc_col = r_rc_col + COL_W'(1);
            end
        end

        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    restart = 1'b1;
                    n_state = SEQ_RUN;
                    if (cfg_w_raw == '0) begin
                        n_w_last      = '0;
                        n_fill_target = FILL_W'(3);
                    end else if (cfg_w_raw > WIDTH_REG_W'(MAX_WIDTH)) begin
                        n_w_last      = COL_W'(MAX_WIDTH - 1);
                        n_fill_target = FILL_W'(MAX_WIDTH + 2);
                    end else begin
                        n_w_last      = COL_W'(cfg_w_raw - WIDTH_REG_W'(1));
                        n_fill_target = FILL_W'(cfg_w_raw) + FILL_W'(2);
                    end
                end
                CFG_IMAGE_HEIGHT: begin
                    restart  = 1'b1;
                    n_state  = SEQ_RUN;
                    n_h_last = (i_cfg_wdata == '0) ? '0 : ROW_W'(i_cfg_wdata - CFG_DATA_W'(1));
                end
                default: begin
                    // index beyond the register list: ignore
                end
            endcase
        end

        // frame restart: drop pending reports and return to row 0, column 0
        if (restart) begin
            n_col     = '0;
            n_fill    = '0;
            n_pending = '0;
            n_rc_col  = '0;
            n_rc_row  = '0;
        end
    end

    always_comb begin
        push_rec.vld           = push;
        push_rec.emit          = emit;
        push_rec.addr          = r_col;
        push_rec.grey          = push_grey;
        push_rec.col           = r_rc_col;
        push_rec.row           = r_rc_row;
        push_rec.border.top    = (r_rc_row == '0);
        push_rec.border.bottom = (r_rc_row == r_h_last);
        push_rec.border.left   = (r_rc_col == '0);
        push_rec.border.right  = (r_rc_col == r_w_last);
        push_rec.last          = push_rec.border.bottom && push_rec.border.right;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= SEQ_RUN;
            r_w_last      <= '0;
            r_h_last      <= '0;
            r_fill_target <= FILL_W'(3);
            r_fill        <= '0;
            r_pending     <= '0;
            r_col         <= '0;
            r_rc_col      <= '0;
            r_rc_row      <= '0;
        end else begin
            r_state       <= n_state;
            r_w_last      <= n_w_last;
            r_h_last      <= n_h_last;
            r_fill_target <= n_fill_target;
            r_fill        <= n_fill;
            r_pending     <= n_pending;
            r_col         <= n_col;
            r_rc_col      <= n_rc_col;
            r_rc_row      <= n_rc_row;
        end
    end

    gndm_line_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_rec),
        .o_flight     (flight),
        .o_beat_valid (beat_valid),
        .o_beat       (beat)
    );

    gndm_result_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (beat_valid),
        .i_wr_data (beat),
        .o_count   (q_count),
        .o_valid   (o_res_valid),
        .o_data    (o_res),
        .i_stall   (i_res_stall)
    );

    a_queue_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occupancy <= Q_CNT_W'(Q_DEPTH))
        else $error("more reports in flight than the result queue can hold");

    a_fill_has_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SEQ_FILL) |-> ((r_pending != '0) && !fill_full))
        else $error("zero fill running with nothing to drain");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        FILL_W'(r_pending) <= r_fill_target)
        else $error("pending reports exceed the window depth");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_fill_target)
        else $error("fill count beyond the window depth");

endmodule
`default_nettype wire

/* rtl/gndm_line_window.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gndm_line_window: line store, 3x3 window and mask
// One RAM holds the two earlier rows per column; each push reads its column,
// and in the cycle after shifts the window and writes the column back.
// ----------------------------------------------------------------------------
module gndm_line_window import gndm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_push       i_push,
    output t_flight          o_flight,
    output logic             o_beat_valid,
    output t_result_out      o_beat
);

    localparam int WORD_W = 2 * GREY_W;

    // Window cells, row-major: top row 0..2, centre row 3..5, bottom row 6..8
    localparam int CELL_UL = 0;
    localparam int CELL_U  = 1;
    localparam int CELL_UR = 2;
    localparam int CELL_L  = 3;
    localparam int CELL_C  = 4;
    localparam int CELL_R  = 5;
    localparam int CELL_DL = 6;
    localparam int CELL_D  = 7;
    localparam int CELL_DR = 8;

    // Mask bit of each direction
    localparam int DIR_U  = 0;
    localparam int DIR_UR = 1;
    localparam int DIR_R  = 2;
    localparam int DIR_DR = 3;
    localparam int DIR_D  = 4;
    localparam int DIR_DL = 5;
    localparam int DIR_L  = 6;
    localparam int DIR_UL = 7;

    logic [WORD_W-1:0]           r_mem [MAX_WIDTH];
    logic [WORD_W-1:0]           r_rd_q;
    logic [WORD_W-1:0]           r_fwd_data;
    logic                        r_fwd;
    t_push                       r_b;
    logic [8:0][GREY_W-1:0]      r_win;
    logic                        r_c_vld;
    logic [COL_W-1:0]            r_c_col;
    logic [ROW_W-1:0]            r_c_row;
    logic                        r_c_last;
    t_border                     r_c_border;

    logic [WORD_W-1:0]           rd_word;
    logic [WORD_W-1:0]           wr_word;
    logic [GREY_W-1:0]           top_grey;
    logic [GREY_W-1:0]           mid_grey;
    logic [MASK_W-1:0]           blocked;

    // Take the word just written when the same column is read back to back
    assign rd_word  = r_fwd ? r_fwd_data : r_rd_q;
    assign top_grey = rd_word[WORD_W-1:GREY_W];
    assign mid_grey = rd_word[GREY_W-1:0];
    assign wr_word  = {mid_grey, r_b.grey};

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_rd_q <= r_mem[i_push.addr];
        end
        if (r_b.vld) begin
            r_mem[r_b.addr] <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.vld <= 1'b0;
            r_fwd   <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_b     <= i_push;
            r_fwd   <= i_push.vld && r_b.vld && (i_push.addr == r_b.addr);
            r_c_vld <= r_b.vld && r_b.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= wr_word;
        r_c_col    <= r_b.col;
        r_c_row    <= r_b.row;
        r_c_last   <= r_b.last;
        r_c_border <= r_b.border;
        if (r_b.vld) begin
            r_win[CELL_UL] <= r_win[CELL_U];
            r_win[CELL_U]  <= r_win[CELL_UR];
            r_win[CELL_UR] <= top_grey;
            r_win[CELL_L]  <= r_win[CELL_C];
            r_win[CELL_C]  <= r_win[CELL_R];
            r_win[CELL_R]  <= mid_grey;
            r_win[CELL_DL] <= r_win[CELL_D];
            r_win[CELL_D]  <= r_win[CELL_DR];
            r_win[CELL_DR] <= r_b.grey;
        end
    end

    always_comb begin
        blocked[DIR_U]  = r_c_border.top    || (r_win[CELL_U]  != r_win[CELL_C]);
        blocked[DIR_UR] = r_c_border.top    || r_c_border.right
                          || (r_win[CELL_UR] != r_win[CELL_C]);
        blocked[DIR_R]  = r_c_border.right  || (r_win[CELL_R]  != r_win[CELL_C]);
        blocked[DIR_DR] = r_c_border.bottom || r_c_border.right
                          || (r_win[CELL_DR] != r_win[CELL_C]);
        blocked[DIR_D]  = r_c_border.bottom || (r_win[CELL_D]  != r_win[CELL_C]);
        blocked[DIR_DL] = r_c_border.bottom || r_c_border.left
                          || (r_win[CELL_DL] != r_win[CELL_C]);
        blocked[DIR_L]  = r_c_border.left   || (r_win[CELL_L]  != r_win[CELL_C]);
        blocked[DIR_UL] = r_c_border.top    || r_c_border.left
                          || (r_win[CELL_UL] != r_win[CELL_C]);
    end

    assign o_beat_valid        = r_c_vld;
    assign o_beat.grey_level   = r_win[CELL_C];
    assign o_beat.blocked_mask = blocked;
    assign o_beat.pixel_column = r_c_col;
    assign o_beat.pixel_row    = r_c_row;
    assign o_beat.frame_last   = r_c_last;

    assign o_flight.b_emit = r_b.vld && r_b.emit;
    assign o_flight.c_emit = r_c_vld;

    a_fwd_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_b.vld)
        else $error("forwarding set without a push in the write stage");

    a_report_follows_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld |-> $past(r_b.vld && r_b.emit))
        else $error("report without an emitting push before it");

    a_last_on_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_vld && r_c_last) |-> (r_c_border.right && r_c_border.bottom))
        else $error("frame end reported away from the bottom right corner");

endmodule
`default_nettype wire

/* rtl/gndm_result_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gndm_result_queue: small result queue in front of the output channel
// Holds finished reports so the pipeline keeps moving while the sink stalls.
// ----------------------------------------------------------------------------
module gndm_result_queue import gndm_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_wr_en,
    input  wire t_result_out  i_wr_data,
    output logic [Q_CNT_W-1:0] o_count,
    output logic              o_valid,
    output t_result_out       o_data,
    input  wire logic         i_stall
);

    t_result_out          r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_q[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_q[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_wr_en && !pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (!i_wr_en && pop) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_en && !pop) |-> (r_count < Q_CNT_W'(Q_DEPTH)))
        else $error("result queue written while full");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == Q_CNT_W'(Q_DEPTH)) || ((r_wr_ptr - r_rd_ptr) == r_count[Q_PTR_W-1:0]))
        else $error("result queue pointers disagree with the count");

endmodule
`default_nettype wire

/* test/tb_grey_neighbour_difference_mask_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grey_neighbour_difference_mask_core: self-checking bench for the core
// Drives pixel and flush beats in random bursts against a stalling receiver.
// A scoreboard class keeps its own line stores and 3x3 window, predicts each
// result beat and checks it field by field.
// ----------------------------------------------------------------------------
module tb_grey_neighbour_difference_mask_core;
    import gndm_pkg::*;

    localparam int          CLK_HALF      = 5;
    // result path depth plus margin, waited out before a register write
    localparam int          SETTLE_CYCLES = 8;
    localparam int          ITEM_TARGET   = 1150;
    localparam int          PRINT_CAP     = 40;
    localparam int unsigned PEND_MAX      = (1 << PEND_W) - 1;

    // neighbour offsets, bit k of the mask is offset k: up first, then clockwise
    localparam int ROW_STEP [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
    localparam int COL_STEP [8] = '{0, 1, 1, 1, 0, -1, -1, -1};

    // frame shapes at the limits of the registers, run first
    localparam int NUM_BOUND        = 6;
    localparam int BOUND_W [NUM_BOUND] = '{0, 2047, 1024, 1, 5, 1};
    localparam int BOUND_H [NUM_BOUND] = '{0, 3, 65535, 65535, 1, 1};

    typedef enum int {
        STALL_NONE,
        STALL_SPARSE,
        STALL_COMB,
        STALL_RUNS
    } t_stall_mode;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the line stores and window of the core
    // ------------------------------------------------------------------------
    class neighbour_mask_tracker;
        logic [WIDTH_REG_W-1:0] width_reg;
        logic [ROW_W-1:0]       height_reg;
        logic [GREY_W-1:0]      upper_line  [MAX_WIDTH];
        logic [GREY_W-1:0]      middle_line [MAX_WIDTH];
        logic [GREY_W-1:0]      window      [9];
        int unsigned            next_col;
        int unsigned            next_row;
        int unsigned            unreported;
        int unsigned            filled;
        t_result_out            awaited [$];
        int                     mismatches;

        function new();
            width_reg  = 1;
            height_reg = 1;
            foreach (upper_line[i]) begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            next_col   = 0;
            next_row   = 0;
            unreported = 0;
            filled     = 0;
            foreach (window[i]) window[i] = '0;
        endfunction

        function int unsigned cols();
            int unsigned w;
            w = width_reg;
            if (w == 0) w = 1;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            return w;
        endfunction

        function int unsigned rows();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_IMAGE_WIDTH) begin
                width_reg = data[WIDTH_REG_W-1:0];
                restart();
            end else if (idx == CFG_IMAGE_HEIGHT) begin
                height_reg = data[ROW_W-1:0];
                restart();
            end
        endfunction

        // push one grey level through the line stores and the window
        function void shift_in(logic [GREY_W-1:0] grey);
            int unsigned       w;
            int unsigned       h;
            int unsigned       c;
            int                r;
            logic [GREY_W-1:0] top;
            logic [GREY_W-1:0] mid;
            w   = cols();
            h   = rows();
            c   = (next_col < w) ? next_col : 0;
            top = upper_line[c];
            mid = middle_line[c];
            upper_line[c]  = mid;
            middle_line[c] = grey;
            for (r = 0; r < 3; r++) begin
                window[r * 3]     = window[r * 3 + 1];
                window[r * 3 + 1] = window[r * 3 + 2];
            end
            window[2] = top;
            window[5] = mid;
            window[8] = grey;
            c++;
            if (c >= w) begin
                c = 0;
                next_row++;
                if (next_row >= h) next_row = 0;
            end
            next_col = c;
            if (filled < w + 2) filled++;
        endfunction

        // mask of the window centre, which sits width+1 places behind the latest arrival
        function t_result_out centre_mask();
            longint            w;
            longint            h;
            longint            frame;
            longint            nxt;
            longint            centre;
            longint            row;
            longint            col;
            longint            rr;
            longint            cc;
            int                k;
            logic [MASK_W-1:0] mask;
            t_result_out       res;
            w      = cols();
            h      = rows();
            frame  = w * h;
            nxt    = ((next_row < h ? next_row : 0) * w + next_col) % frame;
            centre = (nxt + frame - ((w + 2) % frame)) % frame;
            row    = centre / w;
            col    = centre % w;
            mask   = '0;
            for (k = 0; k < 8; k++) begin
                rr = row + ROW_STEP[k];
                cc = col + COL_STEP[k];
                if (rr < 0 || rr >= h || cc < 0 || cc >= w)
                    mask[k] = 1'b1;
                else
                    mask[k] = window[(1 + ROW_STEP[k]) * 3 + 1 + COL_STEP[k]] != window[4];
            end
            res.grey_level   = window[4];
            res.blocked_mask = mask;
            res.pixel_column = col[COL_W-1:0];
            res.pixel_row    = row[ROW_W-1:0];
            res.frame_last   = (centre == frame - 1);
            return res;
        endfunction

        // note one accepted input beat
        function void note_beat(t_pixel_in beat);
            int unsigned w;
            int unsigned sum;
            w = cols();
            if (beat.mode == MODE_PIXEL) begin
                sum = beat.red + beat.green + beat.blue;
                shift_in(GREY_W'(sum / 3));
                if (unreported < PEND_MAX) unreported++;
                if (filled >= w + 2) begin
                    awaited.push_back(centre_mask());
                    unreported--;
                end
            end else if (unreported != 0) begin
                // pad with zero grey until the window is full, then drain one
                do shift_in('0); while (filled < w + 2);
                awaited.push_back(centre_mask());
                unreported--;
                if (unreported == 0) restart();
            end
        endfunction

        task flag(string what);
            if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want,
                         t_result_out ref_res);
            if (got !== want)
                flag($sformatf("%s got %0h want %0h at row %0d col %0d", name, got, want,
                               ref_res.pixel_row, ref_res.pixel_column));
        endtask

        // check one accepted result beat against the oldest prediction
        task check_result(t_result_out got);
            t_result_out want;
            if (awaited.size() == 0) begin
                flag($sformatf("unexpected result beat row %0d col %0d",
                               got.pixel_row, got.pixel_column));
                return;
            end
            want = awaited.pop_front();
            check_field("grey_level", got.grey_level, want.grey_level, want);
            check_field("blocked_mask", got.blocked_mask, want.blocked_mask, want);
            check_field("pixel_column", got.pixel_column, want.pixel_column, want);
            check_field("pixel_row", got.pixel_row, want.pixel_row, want);
            check_field("frame_last", got.frame_last, want.frame_last, want);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_pix_valid = 1'b0;
    logic                  o_pix_stall;
    t_pixel_in             i_pix       = '0;
    logic                  o_res_valid;
    logic                  i_res_stall = 1'b0;
    t_result_out           o_res;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    grey_neighbour_difference_mask_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .o_pix_stall (o_pix_stall),
        .i_pix       (i_pix),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_res       (o_res),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    neighbour_mask_tracker tracker;
    int                    burst_left = 0;
    int                    counted    = 0;
    t_pixel_in             palette [2];

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall on one of four patterns, each kept for a randomly drawn number of cycles
    // ------------------------------------------------------------------------
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;
    logic        run_level  = 1'b0;

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 160);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE: i_res_stall <= 1'b0;
            STALL_SPARSE: i_res_stall <= ($urandom_range(0, 3) == 0);
            STALL_COMB: i_res_stall <= (stall_left % 3 == 0);
            default: begin
                // long runs of stall and of flow
                if ($urandom_range(0, 7) == 0) run_level = !run_level;
                i_res_stall <= run_level;
            end
        endcase
    end

    // Check every result beat taken at this edge; values sampled are pre-edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid === 1'b1 && i_res_stall == 1'b0)
            tracker.check_result(o_res);
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------
    function automatic t_pixel_in pixel(int r, int g, int b);
        t_pixel_in p;
        p.mode  = MODE_PIXEL;
        p.red   = GREY_W'(r);
        p.green = GREY_W'(g);
        p.blue  = GREY_W'(b);
        return p;
    endfunction

    // flush beat; its colour bytes carry noise that the core must ignore
    function automatic t_pixel_in flush_beat();
        t_pixel_in p;
        p      = t_pixel_in'($urandom);
        p.mode = MODE_FLUSH;
        return p;
    endfunction

    // palette colours half of the time so that neighbours often match
    function automatic t_pixel_in pick_pixel();
        t_pixel_in p;
        case ($urandom_range(0, 5))
            0, 1, 2: p = palette[$urandom_range(0, 1)];
            3: begin
                p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: p = t_pixel_in'($urandom);
        endcase
        p.mode = MODE_PIXEL;
        return p;
    endfunction

    // Offer one beat and hold it until taken; open a gap when the burst ends
    task automatic drive_beat(input t_pixel_in beat);
        if (burst_left == 0) begin
            i_pix_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(60, 250)
                                                     : $urandom_range(1, 24);
        end
        i_pix_valid <= 1'b1;
        i_pix       <= beat;
        do @(posedge i_clk); while (o_pix_stall);
        if (beat.mode == MODE_PIXEL || tracker.unreported != 0) counted++;
        tracker.note_beat(beat);
        burst_left--;
    endtask

    // Drop valid and hold off until every predicted result has arrived
    task automatic wait_drained();
        i_pix_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.awaited.size() != 0);
    endtask

    task automatic settle_for_config();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the shape registers on consecutive edges, keeping the enable high
    task automatic program_frame(input bit set_w, input int w, input bit set_h, input int h);
        if (set_w) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= CFG_IMAGE_WIDTH;
            i_cfg_wdata <= CFG_DATA_W'(w);
            @(posedge i_clk);
            tracker.write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        end
        if (set_h) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= CFG_IMAGE_HEIGHT;
            i_cfg_wdata <= CFG_DATA_W'(h);
            @(posedge i_clk);
            tracker.write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // One random phase: reprogram, stream frames, then usually drain
    task automatic run_phase(input int w_set, input int h_set, input bit set_w,
                             input bit set_h);
        int w;
        int h;
        int npix;
        int cap;
        int i;
        settle_for_config();
        program_frame(set_w, w_set, set_h, h_set);
        w          = tracker.cols();
        h          = tracker.rows();
        palette[0] = pick_pixel();
        palette[1] = pick_pixel();
        // keep wide frames short: an early flush already pads a whole row
        cap  = (w >= 256) ? 40 : 150;
        npix = w * h * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) npix = $urandom_range(1, npix);
        if (npix > cap) npix = cap;
        for (i = 0; i < npix; i++) begin
            if ($urandom_range(0, 15) == 0) drive_beat(flush_beat());
            if (i == npix / 2 && $urandom_range(0, 2) == 0) wait_drained();
            drive_beat(pick_pixel());
        end
        // now and then leave results pending so the next write abandons them
        if ($urandom_range(0, 4) != 0)
            while (tracker.unreported != 0) drive_beat(flush_beat());
        if ($urandom_range(0, 3) == 0) drive_beat(flush_beat());
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int w;
        int h;
        int sel;
        int phase;
        tracker = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 frame: flush with nothing pending, extreme colours, equal greys
        program_frame(1'b1, 3, 1'b1, 3);
        drive_beat(flush_beat());
        drive_beat(pixel(0, 0, 0));
        drive_beat(pixel(255, 255, 255));
        drive_beat(pixel(255, 0, 0));
        drive_beat(pixel(0, 255, 0));
        drive_beat(pixel(0, 0, 255));
        drive_beat(pixel(1, 1, 1));
        drive_beat(pixel(2, 1, 0));
        drive_beat(pixel(255, 255, 254));
        drive_beat(pixel(128, 128, 128));
        // pause the sender until every result so far has come back
        wait_drained();
        while (tracker.unreported != 0) drive_beat(flush_beat());
        drive_beat(flush_beat());
        // after a full drain this pixel opens a fresh frame; the write aborts it
        drive_beat(pixel(7, 8, 9));

        // flush before the window is full: neighbours not yet seen read as zero
        settle_for_config();
        program_frame(1'b1, 4, 1'b1, 2);
        drive_beat(pixel(30, 30, 30));
        drive_beat(pixel(30, 30, 30));
        drive_beat(pixel(0, 0, 0));
        while (tracker.unreported != 0) drive_beat(flush_beat());

        // one-row frames back to back
        settle_for_config();
        program_frame(1'b1, 2, 1'b1, 1);
        drive_beat(pixel(9, 9, 9));
        drive_beat(pixel(9, 9, 9));
        drive_beat(pixel(9, 9, 9));
        drive_beat(pixel(200, 10, 0));
        while (tracker.unreported != 0) drive_beat(flush_beat());

        // random phases, limit shapes first
        phase = 0;
        while (counted < ITEM_TARGET) begin
            if (phase < NUM_BOUND) begin
                run_phase(BOUND_W[phase], BOUND_H[phase], 1'b1, 1'b1);
            end else begin
                w   = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 9);
                h   = $urandom_range(1, 6);
                sel = $urandom_range(0, 3);
                run_phase(w, h, sel != 1, sel != 0);
            end
            phase++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/gndm_pkg.sv
rtl/gndm_line_window.sv
rtl/gndm_result_queue.sv
rtl/grey_neighbour_difference_mask_core.sv
test/tb_grey_neighbour_difference_mask_core.sv
